// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the region map RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PARM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("region map check failed");

// Check that a condition implies a consequence in the same cycle.
`define PARM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("region map implication failed");

`endif

// ===== hdl/parm_pkg.sv =====
// Package for the paged address region map: sizes, status codes, region type.
// Used by parm_region_store and paged_address_region_map_unit. No dependencies.
`timescale 1ns / 1ps

package parm_pkg;

	localparam int MEM_SIZE_LOG2 = 24;
	localparam int PAGE_SIZE_LOG2 = 20;
	localparam int MAX_REGIONS_PER_PAGE = 8;

	localparam int PAGE_BITS = MEM_SIZE_LOG2 - PAGE_SIZE_LOG2;
	localparam int PG_W = (PAGE_BITS > 0) ? PAGE_BITS : 1;
	localparam int ROW_W = PG_W + 1;
	localparam int ROW_DEPTH = 1 << ROW_W;
	localparam int SLOT_W = (MAX_REGIONS_PER_PAGE > 1) ? $clog2(MAX_REGIONS_PER_PAGE) : 1;
	localparam int COUNT_W = $clog2(MAX_REGIONS_PER_PAGE + 1);
	localparam int ENTRY_W = ROW_W + SLOT_W;
	localparam int ENTRY_DEPTH = 1 << ENTRY_W;

	localparam logic [32:0] MEM_LIMIT = (33'd1 << MEM_SIZE_LOG2) - 33'd1;
	localparam logic [32:0] PAGE_SPAN = 33'd1 << PAGE_SIZE_LOG2;
	localparam logic [31:0] ALIGN_MASK = 32'h0000_000f;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_UNMAPPED = 3'd1;
	localparam logic [2:0] ST_BAD_RANGE = 3'd2;
	localparam logic [2:0] ST_PAGE_FULL = 3'd3;
	localparam logic [2:0] ST_BEYOND = 3'd4;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_ADD = 1'b1;

	localparam logic [1:0] MAP_READ = 2'd0;
	localparam logic [1:0] MAP_WRITE = 2'd1;

	typedef struct packed {
		logic [31:0] start_addr;
		logic [31:0] end_addr;
		logic [31:0] bias;
		logic [5:0]  owner;
	} region_t;

	// Base address of a page, one bit wider than an address.
	function automatic logic [32:0] page_base(input logic [PG_W-1:0] pg);
		return 33'(pg) << PAGE_SIZE_LOG2;
	endfunction

endpackage

// ===== hdl/parm_region_store.sv =====
// Region entry memory for both maps, with per-row valid bits for reset state.
// Depends on parm_pkg. One write and one registered read per cycle.
`timescale 1ns / 1ps

module parm_region_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [parm_pkg::ENTRY_W-1:0] rd_addr,
	output parm_pkg::region_t        rd_data,
	input  logic                     wr_en,
	input  logic [parm_pkg::ENTRY_W-1:0] wr_addr,
	input  parm_pkg::region_t        wr_data
);
	import parm_pkg::*;

	region_t               mem_q [ENTRY_DEPTH];
	logic [ROW_DEPTH-1:0]  row_valid_q;
	region_t               rd_raw_s1;
	logic [ENTRY_W-1:0]    rd_addr_s1;
	logic                  rd_valid_s1;
	logic [32:0]           pb;
	region_t               dflt;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_s1 <= mem_q[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	// Mark a row as written; until then it reads as its reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr[ENTRY_W-1:SLOT_W]] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr[ENTRY_W-1:SLOT_W]];
			end
		end
	end

	// Reset contents: slot zero covers the whole page with no owner
	always_comb begin
		pb = page_base(rd_addr_s1[SLOT_W +: PG_W]);
		dflt = '0;
		if (rd_addr_s1[SLOT_W-1:0] == '0) begin
			dflt.start_addr = pb[31:0];
			dflt.end_addr = 32'(pb + PAGE_SPAN - 33'd1);
			dflt.bias = pb[31:0];
		end
	end

	assign rd_data = rd_valid_s1 ? rd_raw_s1 : dflt;

endmodule

// ===== hdl/paged_address_region_map_unit.sv =====
// Top level of the paged address region map: sequencer, row buffer, counts.
// Depends on parm_pkg, parm_region_store and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Paged address decoder with separate read and write maps. One item is in
// flight at a time; in_ready is high only when the sequencer is idle. All
// region entries sit in one memory with one read and one write port, so
// every row is walked one entry per cycle. An access decodes, then reads
// the row of its page until the matching region (its slot at most
// MAX_REGIONS_PER_PAGE - 1) or the end of the row, then responds. An add
// checks the row of each touched page of each selected map and, if every
// row fits, rewrites each such row (cnt regions before, n after). Bad
// ranges and addresses beyond memory answer straight from decode. A
// result waits in the output register while the next item is accepted.
module paged_address_region_map_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [1:0]  map_select,
	input  logic [31:0] access_address,
	input  logic [31:0] range_base,
	input  logic [31:0] range_size,
	input  logic [5:0]  target_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [5:0]  hit_target,
	output logic [31:0] local_offset
);
	import parm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LK = 4'd2;
	localparam logic [3:0] S_LKEND = 4'd3;
	localparam logic [3:0] S_ROW = 4'd4;
	localparam logic [3:0] S_LD = 4'd5;
	localparam logic [3:0] S_LAST = 4'd6;
	localparam logic [3:0] S_EVAL = 4'd7;
	localparam logic [3:0] S_WR = 4'd8;
	localparam logic [3:0] S_RESP = 4'd9;

	logic [3:0]         state_q;
	logic               op_q;
	logic [1:0]         sel_q;
	logic [31:0]        addr_q, base_q, size_q, limit_q, nb_q, nl_q;
	logic [5:0]         owner_q;
	logic [PG_W-1:0]    first_pg_q, last_pg_q, pg_q;
	logic               map_q, pass_q;
	logic [COUNT_W-1:0] cnt_q, head_q, tail_q, n_q;
	logic [SLOT_W-1:0]  rd_idx_q, wr_idx_q, rd_slot_s1;
	logic               rd_issue_s1;
	logic [2:0]         res_status_q, out_status_q;
	logic [5:0]         res_target_q, out_target_q;
	logic [31:0]        res_local_q, out_local_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] count_q [ROW_DEPTH];
	region_t            buf_q [MAX_REGIONS_PER_PAGE];

	logic               do_read, do_write;
	logic [ROW_W-1:0]   row;
	logic [32:0]        pb, pl, lim33;
	logic [31:0]        row_nb, row_nl;
	logic               last_rd, lk_hit, can_load;
	logic [COUNT_W:0]   n_sum;
	logic [PG_W-1:0]    addr_pg;
	logic               rd_en, wr_en;
	logic [ENTRY_W-1:0] rd_addr, wr_addr;
	region_t            rd_data, wr_data, buf_sel;
	logic [COUNT_W-1:0] kx;
	logic [SLOT_W-1:0]  src_idx;
	logic               bad_range;

	assign do_read = (sel_q != MAP_WRITE);
	assign do_write = (sel_q != MAP_READ);
	assign row = {map_q, pg_q};
	assign addr_pg = PG_W'(access_address >> PAGE_SIZE_LOG2);

	// Clip the range to the current page
	always_comb begin
		pb = page_base(pg_q);
		pl = pb + PAGE_SPAN - 33'd1;
		row_nb = ({1'b0, base_q} > pb) ? base_q : pb[31:0];
		row_nl = ({1'b0, limit_q} < pl) ? limit_q : pl[31:0];
	end

	assign lim33 = {1'b0, base_q} + {1'b0, size_q} - 33'd1;
	assign bad_range = ((base_q & ALIGN_MASK) != '0) || ((size_q & ALIGN_MASK) != '0) ||
		(size_q == '0) || lim33[32];

	assign last_rd = (COUNT_W'(rd_idx_q) == cnt_q - COUNT_W'(1));
	assign lk_hit = rd_issue_s1 && (rd_data.start_addr <= addr_q) &&
		(addr_q <= rd_data.end_addr);
	assign n_sum = (COUNT_W+1)'(head_q) + (COUNT_W+1)'(tail_q) + (COUNT_W+1)'(1);
	assign can_load = !out_valid_q || out_ready;

	// Entry memory access
	assign rd_en = (state_q == S_LK) || (state_q == S_LD);
	assign rd_addr = {row, rd_idx_q};
	assign wr_en = (state_q == S_WR);
	assign wr_addr = {row, wr_idx_q};

	// Build the rewritten row: heads in place, new region, tails shifted
	always_comb begin
		kx = COUNT_W'(wr_idx_q);
		if (kx < head_q) begin
			src_idx = wr_idx_q;
		end else begin
			src_idx = SLOT_W'(kx + cnt_q - n_q);
		end
		buf_sel = buf_q[src_idx];
		wr_data = buf_sel;
		if (kx < head_q) begin
			wr_data.end_addr = (buf_sel.end_addr < nb_q) ? buf_sel.end_addr : nb_q - 32'd1;
		end else if (kx == head_q) begin
			wr_data.start_addr = nb_q;
			wr_data.end_addr = nl_q;
			wr_data.bias = base_q;
			wr_data.owner = owner_q;
		end else begin
			wr_data.start_addr = (buf_sel.start_addr > nl_q) ? buf_sel.start_addr
				: nl_q + 32'd1;
		end
	end

	parm_region_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Capture the item and hold the row buffer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= operation;
			sel_q <= map_select;
			addr_q <= access_address;
			base_q <= range_base;
			size_q <= range_size;
			owner_q <= target_id;
		end
		if (rd_issue_s1 && ((state_q == S_LD) || (state_q == S_LAST))) begin
			buf_q[rd_slot_s1] <= rd_data;
		end
		rd_slot_s1 <= rd_idx_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_issue_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			map_q <= 1'b0;
			pass_q <= 1'b0;
			pg_q <= '0;
			first_pg_q <= '0;
			last_pg_q <= '0;
			limit_q <= '0;
			nb_q <= '0;
			nl_q <= '0;
			cnt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			n_q <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			res_status_q <= ST_OK;
			res_target_q <= '0;
			res_local_q <= '0;
			out_status_q <= ST_OK;
			out_target_q <= '0;
			out_local_q <= '0;
			for (int r = 0; r < ROW_DEPTH; r++) begin
				count_q[r] <= COUNT_W'(1);
			end
		end else begin
			rd_issue_s1 <= rd_en;
			// Drop the result once taken, unless a new one loads in its place
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			// Tally heads and tails as row entries come back
			if (rd_issue_s1 && ((state_q == S_LD) || (state_q == S_LAST))) begin
				head_q <= head_q + COUNT_W'(rd_data.start_addr < nb_q);
				tail_q <= tail_q + COUNT_W'(rd_data.end_addr > nl_q);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
						// Lookup row is known at acceptance
						map_q <= map_select[0];
						pg_q <= addr_pg;
						cnt_q <= count_q[{map_select[0], addr_pg}];
					end
				end
				S_DECODE: begin
					res_target_q <= '0;
					res_local_q <= '0;
					rd_idx_q <= '0;
					if (op_q == OP_ACCESS) begin
						if ({1'b0, addr_q} > MEM_LIMIT) begin
							res_status_q <= ST_BEYOND;
							state_q <= S_RESP;
						end else begin
							res_status_q <= ST_UNMAPPED;
							state_q <= S_LK;
						end
					end else if (bad_range) begin
						res_status_q <= ST_BAD_RANGE;
						state_q <= S_RESP;
					end else if (lim33 > MEM_LIMIT) begin
						res_status_q <= ST_BEYOND;
						state_q <= S_RESP;
					end else begin
						limit_q <= lim33[31:0];
						first_pg_q <= PG_W'(base_q >> PAGE_SIZE_LOG2);
						last_pg_q <= PG_W'(lim33 >> PAGE_SIZE_LOG2);
						pg_q <= PG_W'(base_q >> PAGE_SIZE_LOG2);
						map_q <= !do_read;
						pass_q <= 1'b0;
						res_status_q <= ST_OK;
						state_q <= S_ROW;
					end
				end
				S_LK: begin
					if (lk_hit) begin
						res_target_q <= rd_data.owner;
						res_local_q <= addr_q - rd_data.bias;
						res_status_q <= (rd_data.owner != '0) ? ST_OK : ST_UNMAPPED;
						state_q <= S_RESP;
					end else if (last_rd) begin
						state_q <= S_LKEND;
					end else begin
						rd_idx_q <= rd_idx_q + SLOT_W'(1);
					end
				end
				S_LKEND: begin
					if (lk_hit) begin
						res_target_q <= rd_data.owner;
						res_local_q <= addr_q - rd_data.bias;
						res_status_q <= (rd_data.owner != '0) ? ST_OK : ST_UNMAPPED;
					end
					state_q <= S_RESP;
				end
				S_ROW: begin
					nb_q <= row_nb;
					nl_q <= row_nl;
					cnt_q <= count_q[row];
					rd_idx_q <= '0;
					head_q <= '0;
					tail_q <= '0;
					state_q <= S_LD;
				end
				S_LD: begin
					if (last_rd) begin
						state_q <= S_LAST;
					end else begin
						rd_idx_q <= rd_idx_q + SLOT_W'(1);
					end
				end
				S_LAST: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					n_q <= COUNT_W'(n_sum);
					wr_idx_q <= '0;
					if (pass_q) begin
						state_q <= S_WR;
					end else if (n_sum > (COUNT_W+1)'(MAX_REGIONS_PER_PAGE)) begin
						res_status_q <= ST_PAGE_FULL;
						state_q <= S_RESP;
					end else if (pg_q != last_pg_q) begin
						pg_q <= pg_q + PG_W'(1);
						state_q <= S_ROW;
					end else if (!map_q && do_write) begin
						map_q <= 1'b1;
						pg_q <= first_pg_q;
						state_q <= S_ROW;
					end else begin
						// All rows fit: start the commit pass
						pass_q <= 1'b1;
						map_q <= !do_read;
						pg_q <= first_pg_q;
						state_q <= S_ROW;
					end
				end
				S_WR: begin
					if (kx == n_q - COUNT_W'(1)) begin
						count_q[row] <= n_q;
						if (pg_q != last_pg_q) begin
							pg_q <= pg_q + PG_W'(1);
							state_q <= S_ROW;
						end else if (!map_q && do_write) begin
							map_q <= 1'b1;
							pg_q <= first_pg_q;
							state_q <= S_ROW;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						wr_idx_q <= wr_idx_q + SLOT_W'(1);
					end
				end
				S_RESP: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_target_q <= res_target_q;
						out_local_q <= res_local_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign hit_target = out_target_q;
	assign local_offset = out_local_q;

	// Rows are rewritten only in the commit pass of an add
	`PARM_ASSERT_IMPLY(a_wr_commit, state_q == S_WR, pass_q && (op_q == OP_ADD))
	// Every row holds between one and the maximum number of regions
	`PARM_ASSERT_IMPLY(a_cnt_range, state_q == S_EVAL, (cnt_q != '0) && (cnt_q <= COUNT_W'(MAX_REGIONS_PER_PAGE)))
	// The commit pass only sees rows that the check pass found to fit
	`PARM_ASSERT_IMPLY(a_commit_fits, (state_q == S_EVAL) && pass_q, n_sum <= (COUNT_W+1)'(MAX_REGIONS_PER_PAGE))
	// A result is presented only from the response step
	`PARM_ASSERT(a_out_from_resp, $rose(out_valid_q) |-> $past(state_q == S_RESP))

endmodule
